@@ src/sust_pkg.sv @@
// Package for the sorted unique set table: sizes, command and status codes,
// and the control bundle that the top level sends down the row of cells.
// No dependencies.
package sust_pkg;

  // Table size and derived widths.
  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Request commands; the unused code behaves as a search.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_DELETED   = 3'd5,
    ST_DEL_MISS  = 3'd6
  } status_t;

  // What every cell does in the update cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMP   = 2'd1,
    S_APPLY = 2'd2
  } state_t;

  // Control broadcast to all cells.
  typedef struct packed {
    logic                    compare;
    cell_op_t                op;
    logic signed [KEY_W-1:0] req_key;
  } cell_ctl_t;

endpackage

@@ src/sust_req_if.sv @@
// Request channel: command and key with a valid/ready handshake.
// Depends on sust_pkg for the key width.
interface sust_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [sust_pkg::KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

@@ src/sust_rsp_if.sv @@
// Result channel: status, position and entry count with a valid/ready handshake.
// Depends on sust_pkg for the position and count widths.
interface sust_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [sust_pkg::IDX_W-1:0] position;
  logic [sust_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

@@ src/sorted_unique_set_table_core.sv @@
// Top level of the sorted unique set table: request sequencer, row of cells,
// and result register. Depends on sust_pkg, sust_req_if, sust_rsp_if, sust_cell.
//
// The table keeps up to CAPACITY distinct signed keys in ascending order in a
// row of cells, each holding one key. A request transaction passes through the
// sequencer states S_IDLE, which captures it, S_CMP, in which every cell compares
// its key with the request key in parallel, and S_APPLY, in which the row shifts
// right to open a slot or left to close one and the result is written to the
// output register. The sequencer handles one request at a time: it takes no new
// request until the previous one has left S_APPLY. The result register lets the next request
// enter while the previous result waits to be taken; the update cycle stalls
// only while that register is still full. Reset empties the table at once.
module sorted_unique_set_table_core (
  input logic clk,
  input logic rst,
  sust_req_if.sink   req,
  sust_rsp_if.source rsp
);
  import sust_pkg::*;

  state_t state, state_next;

  logic [1:0]              req_cmd;
  logic signed [KEY_W-1:0] req_key;
  logic [CNT_W-1:0]        count, count_next;

  logic             rsp_valid;
  status_t          rsp_status, status_next;
  logic [IDX_W-1:0] rsp_position, position_next;
  logic [CNT_W-1:0] rsp_count;

  cell_ctl_t ctl;
  cell_op_t  op_next;
  logic      apply_go;
  logic      hit, full;
  logic [IDX_W-1:0] idx;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     valid_vec, lt_vec, eq_vec;

  // Row of cells, each wired to both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_lt, left_valid, right_valid;
    logic signed [KEY_W-1:0] left_key, right_key;
    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_valid = 1'b0;
      assign left_key   = '0;
    end else begin : g_inner_l
      assign left_lt    = lt_vec[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_key   = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_key   = '0;
    end else begin : g_inner_r
      assign right_valid = valid_vec[i+1];
      assign right_key   = cell_key[i+1];
    end
    sust_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_lt    (left_lt),
      .left_key   (left_key),
      .left_valid (left_valid),
      .right_key  (right_key),
      .right_valid(right_valid),
      .key        (cell_key[i]),
      .valid      (valid_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  // The less-than flags form a prefix, so the first clear flag is the index.
  always_comb begin
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!lt_vec[i]) idx = IDX_W'(i);
    end
  end

  assign hit  = |eq_vec;
  assign full = (count == CNT_W'(CAPACITY));

  // Decide the result and the row operation from the compare flags.
  always_comb begin
    op_next       = OP_HOLD;
    status_next   = ST_NOT_FOUND;
    position_next = '0;
    count_next    = count;
    case (req_cmd)
      CMD_INSERT: begin
        if (hit) begin
          status_next   = ST_DUPLICATE;
          position_next = idx;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next   = ST_INSERTED;
          position_next = idx;
          op_next       = OP_INSERT;
          count_next    = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          status_next   = ST_DELETED;
          position_next = idx;
          op_next       = OP_DELETE;
          count_next    = count - CNT_W'(1);
        end else begin
          status_next = ST_DEL_MISS;
        end
      end
      default: begin
        if (hit) begin
          status_next   = ST_FOUND;
          position_next = idx;
        end
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req.valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready   = (state == S_IDLE);
    apply_go    = (state == S_APPLY) && (!rsp_valid || rsp.ready);
    ctl.compare = (state == S_CMP);
    ctl.op      = apply_go ? op_next : OP_HOLD;
    ctl.req_key = req_key;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_cmd <= req.command;
      req_key <= req.key;
    end
    if (apply_go) begin
      rsp_status   <= status_next;
      rsp_position <= position_next;
      rsp_count    <= count_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.position    = rsp_position;
  assign rsp.entry_count = rsp_count;

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The valid cells are exactly as many as the count says.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("cell valid flags disagree with the entry count");

  // Keys are distinct, so at most one cell can match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the request key");

  // An update always leaves a result waiting in the next cycle.
  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    apply_go |=> rsp_valid)
    else $error("update cycle produced no result");

endmodule

@@ src/sust_cell.sv @@
// One cell of the sorted chain: holds one key and its valid flag, compares it
// with the request key and shifts toward either neighbor. Depends on sust_pkg.
module sust_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  sust_pkg::cell_ctl_t               ctl,
  input  logic                              left_lt,
  input  logic signed [sust_pkg::KEY_W-1:0] left_key,
  input  logic                              left_valid,
  input  logic signed [sust_pkg::KEY_W-1:0] right_key,
  input  logic                              right_valid,
  output logic signed [sust_pkg::KEY_W-1:0] key,
  output logic                              valid,
  output logic                              lt,
  output logic                              eq
);
  import sust_pkg::*;

  logic signed [KEY_W-1:0] key_next;
  logic                    valid_next;

  // Cells below the request key stay put; the rest open a gap or close one.
  always_comb begin
    key_next   = key;
    valid_next = valid;
    case (ctl.op)
      OP_INSERT: begin
        if (!lt) begin
          if (left_lt) begin
            key_next   = ctl.req_key;
            valid_next = 1'b1;
          end else begin
            key_next   = left_key;
            valid_next = left_valid;
          end
        end
      end
      OP_DELETE: begin
        if (!lt) begin
          key_next   = right_key;
          valid_next = right_valid;
        end
      end
      default: begin
        key_next   = key;
        valid_next = valid;
      end
    endcase
  end

  // Control flags of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      lt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctl.compare) begin
        lt <= valid && (key < ctl.req_key);
        eq <= valid && (key == ctl.req_key);
      end
    end
  end

  // Key storage needs no reset; it is read only behind its valid flag.
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule
